[hw/rtl/delay_scan_window_center_top_defines.svh]
// ----------------------------------------------------------------------------
// Delay scan window center - assertion macros
// Concurrent assertion helpers shared by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef DELAY_SCAN_WINDOW_CENTER_TOP_DEFINES_SVH
`define DELAY_SCAN_WINDOW_CENTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSWC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dswc_pkg.sv]
// ----------------------------------------------------------------------------
// Delay scan window center - package
// Field widths and the window result type.
// ----------------------------------------------------------------------------
package dswc_pkg;

	localparam int UNIT_W = 3;
	localparam int WORD_W = 32;
	localparam int TAP_W  = 9;

	typedef logic [TAP_W-1:0] tap_t;

	typedef struct packed {
		tap_t win_start;
		tap_t win_end;
		tap_t centre;
	} window_t;

endpackage

[hw/rtl/delay_scan_window_center_top.sv]
// ----------------------------------------------------------------------------
// Delay scan window center - top level
// Finds the longest run of identical captured words over a delay scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transaction per delay tap, in tap
//   order, carrying afe_id, sample_word and last_tap (set on the final tap).
//   Output channel (out_valid/out_ready): one transaction per scan, issued for
//   the tap with last_tap set: unit_out, window_start, window_end, best_tap.
//   A last tap passes the input register, then the result register.
//   Throughput: one tap per clock unless a last tap waits for the output slot,
//   set by the combinational compare and run-counter update in the tracker.
//   A stalled result sits in the output register; further non-last taps keep
//   flowing in. Only a second last tap waits in the input register until the
//   pending result is taken, and in_ready then drops.
//   Reset (arst_n low) clears both valid flags and re-arms the scan state:
//   the next tap accepted is tap 0 of a new scan. After a last tap the scan
//   re-arms by itself.
//   Taps beyond MAX_TAPS are ignored except that a last tap still closes.
// ----------------------------------------------------------------------------
`include "delay_scan_window_center_top_defines.svh"

module delay_scan_window_center_top #(
	parameter int MAX_TAPS = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dswc_pkg::UNIT_W-1:0]   afe_id,
	input  logic [dswc_pkg::WORD_W-1:0]   sample_word,
	input  logic                          last_tap,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dswc_pkg::UNIT_W-1:0]   unit_out,
	output logic [dswc_pkg::TAP_W-1:0]    window_start,
	output logic [dswc_pkg::TAP_W-1:0]    window_end,
	output logic [dswc_pkg::TAP_W-1:0]    best_tap
);

	// input register stage
	logic                          valid_s1;
	logic [dswc_pkg::UNIT_W-1:0]   unit_s1;
	logic [dswc_pkg::WORD_W-1:0]   word_s1;
	logic                          last_s1;

	// result register
	logic                          out_valid_q;
	logic [dswc_pkg::UNIT_W-1:0]   unit_q;
	dswc_pkg::window_t             win_q;

	dswc_pkg::window_t             win;
	logic                          adv_s1;
	logic                          out_free;

	// Non-last taps never need the output slot, so they always move on
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			unit_s1 <= afe_id;
			word_s1 <= sample_word;
			last_s1 <= last_tap;
		end
	end

	dswc_tracker #(
		.MAX_TAPS (MAX_TAPS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (adv_s1),
		.word   (word_s1),
		.last   (last_s1),
		.win    (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			unit_q <= unit_s1;
			win_q  <= win;
		end
	end

	assign out_valid    = out_valid_q;
	assign unit_out     = unit_q;
	assign window_start = win_q.win_start;
	assign window_end   = win_q.win_end;
	assign best_tap     = win_q.centre;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`DSWC_ASSERT_NOW(a_nonlast_flows, clk, arst_n, valid_s1 && !last_s1, adv_s1,
		"non-last tap stalled in input stage")
	`DSWC_ASSERT_NEXT(a_last_gives_result, clk, arst_n, adv_s1 && last_s1, out_valid_q,
		"closing tap produced no result")
	`DSWC_ASSERT_NOW(a_centre_in_window, clk, arst_n, out_valid_q && (MAX_TAPS <= 512),
		(win_q.win_start <= win_q.centre) && (win_q.centre <= win_q.win_end),
		"center tap outside window")

endmodule

[hw/rtl/dswc_tracker.sv]
// ----------------------------------------------------------------------------
// Delay scan window center - run tracker
// Holds the scan state (previous word, tap count, current and longest run)
// and forms the window of the transaction being taken.
// ----------------------------------------------------------------------------
module dswc_tracker #(
	parameter int MAX_TAPS = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [dswc_pkg::WORD_W-1:0]     word,
	input  logic                            last,
	output dswc_pkg::window_t               win
);

	// Count width: holds 0..MAX_TAPS
	localparam int CW = $clog2(MAX_TAPS + 1);
	localparam int EW = (CW > dswc_pkg::TAP_W) ? CW : dswc_pkg::TAP_W;

	logic [dswc_pkg::WORD_W-1:0] prev_word_q;
	logic [CW-1:0]               tap_count_q;
	logic [CW-1:0]               run_len_q;
	logic [CW-1:0]               run_start_q;
	logic [CW-1:0]               best_len_q;
	logic [CW-1:0]               best_start_q;

	logic [CW-1:0] run_len_n, run_start_n, best_len_n, best_start_n, tap_count_n;
	logic [CW-1:0] sel_len, sel_start, len_m1, end_tap, centre_tap;
	logic [EW-1:0] start_x, end_x, centre_x;

	always_comb begin
		run_len_n    = run_len_q;
		run_start_n  = run_start_q;
		best_len_n   = best_len_q;
		best_start_n = best_start_q;
		tap_count_n  = tap_count_q;
		if (tap_count_q == '0) begin
			// first tap opens a run at tap 0
			run_len_n    = CW'(1);
			run_start_n  = '0;
			best_len_n   = CW'(1);
			best_start_n = '0;
			tap_count_n  = CW'(1);
		end else if (tap_count_q < CW'(MAX_TAPS)) begin
			if (word == prev_word_q) begin
				run_len_n = run_len_q + CW'(1);
			end else begin
				if (run_len_q > best_len_q) begin
					best_len_n   = run_len_q;
					best_start_n = run_start_q;
				end
				run_len_n   = CW'(1);
				run_start_n = tap_count_q;
			end
			tap_count_n = tap_count_q + CW'(1);
		end
	end

	// Close-out: strictly longer run wins, so a tie keeps the earlier one
	always_comb begin
		if (run_len_n > best_len_n) begin
			sel_len   = run_len_n;
			sel_start = run_start_n;
		end else begin
			sel_len   = best_len_n;
			sel_start = best_start_n;
		end
		len_m1     = sel_len - CW'(1);
		end_tap    = sel_start + len_m1;
		centre_tap = sel_start + (len_m1 >> 1);
		start_x    = EW'(sel_start);
		end_x      = EW'(end_tap);
		centre_x   = EW'(centre_tap);
		win.win_start = start_x[dswc_pkg::TAP_W-1:0];
		win.win_end   = end_x[dswc_pkg::TAP_W-1:0];
		win.centre    = centre_x[dswc_pkg::TAP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_word_q  <= '0;
			tap_count_q  <= '0;
			run_len_q    <= CW'(1);
			run_start_q  <= '0;
			best_len_q   <= CW'(1);
			best_start_q <= '0;
		end else if (take) begin
			if (tap_count_q == '0 || tap_count_q < CW'(MAX_TAPS)) begin
				prev_word_q <= word;
			end
			if (last) begin
				// re-arm for the next scan
				tap_count_q  <= '0;
				run_len_q    <= CW'(1);
				run_start_q  <= '0;
				best_len_q   <= CW'(1);
				best_start_q <= '0;
			end else begin
				tap_count_q  <= tap_count_n;
				run_len_q    <= run_len_n;
				run_start_q  <= run_start_n;
				best_len_q   <= best_len_n;
				best_start_q <= best_start_n;
			end
		end
	end

endmodule
